// ===== rtl/fptok_pkg.sv =====
// ----------------------------------------------------------------------------
// fptok_pkg
// types and constants shared by the sequence record tokenizer modules
// ----------------------------------------------------------------------------
package fptok_pkg;

	// register codes for format_mode
	localparam logic [1:0] MODE_AUTO  = 2'd0;
	localparam logic [1:0] MODE_FASTA = 2'd1;
	localparam logic [1:0] MODE_PLAIN = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_HT      = 8'h09;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// output queue depth in tokens
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SEQ    = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FMT_UNDECIDED = 2'd0,
		FMT_FASTA     = 2'd1,
		FMT_PLAIN     = 2'd2
	} fmt_t;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_SEQ    = 5'b00100,
		PH_PSKIP  = 5'b01000,
		PH_LINE   = 5'b10000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} token_t;

	// tokens produced by one byte, cnt is 0, 1 or 2
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

// ===== rtl/fptok_if.sv =====
// ----------------------------------------------------------------------------
// fptok channel interfaces
// valid/ready channels for raw file bytes and for output tokens
// ----------------------------------------------------------------------------
interface fptok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface fptok_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] token_kind;
	logic [7:0] out_char;
	logic       run_last;

	modport source (output valid, output token_kind, output out_char, output run_last,
		input ready);
	modport sink   (input valid, input token_kind, input out_char, input run_last,
		output ready);
endinterface

// ===== rtl/fptok_parser.sv =====
// ----------------------------------------------------------------------------
// fptok_parser
// input register, record state machine and per-byte token decode
// ----------------------------------------------------------------------------
module fptok_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eoi,
	input  logic [1:0]          format_mode,
	input  logic                room,
	output fptok_pkg::push_t    push
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eoi_s1;
	fptok_pkg::phase_t   phase_q, phase_d;
	fptok_pkg::fmt_t     fmt_q, fmt_d, fmt_cur;
	logic                adv;
	logic                in_acc;
	logic                ws, eol;
	logic                emit_a;
	fptok_pkg::kind_t    kind_a;
	logic [7:0]          ch_a;
	logic                emit_end;
	fptok_pkg::token_t   end_tok;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !room);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			eoi_s1  <= in_eoi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fptok_pkg::PH_START;
			fmt_q   <= fptok_pkg::FMT_UNDECIDED;
		end else if (adv) begin
			phase_q <= phase_d;
			fmt_q   <= fmt_d;
		end
	end

	assign ws  = (byte_s1 == fptok_pkg::CH_SP) ||
		((byte_s1 >= fptok_pkg::CH_HT) && (byte_s1 <= fptok_pkg::CH_CR));
	assign eol = (byte_s1 == fptok_pkg::CH_LF) || (byte_s1 == fptok_pkg::CH_CR);

	always_comb begin
		fmt_cur = fmt_q;
		if (fmt_q == fptok_pkg::FMT_UNDECIDED) begin
			if (format_mode == fptok_pkg::MODE_FASTA) begin
				fmt_cur = fptok_pkg::FMT_FASTA;
			end else if (format_mode == fptok_pkg::MODE_PLAIN) begin
				fmt_cur = fptok_pkg::FMT_PLAIN;
			end else if (!ws) begin
				fmt_cur = (byte_s1 == fptok_pkg::CH_GT) ? fptok_pkg::FMT_FASTA
					: fptok_pkg::FMT_PLAIN;
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		emit_a  = 1'b0;
		kind_a  = fptok_pkg::KIND_SEQ;
		ch_a    = byte_s1;
		case (phase_q)
			fptok_pkg::PH_START: begin
				if (!ws) begin
					if (fmt_cur == fptok_pkg::FMT_FASTA && byte_s1 == fptok_pkg::CH_GT) begin
						phase_d = fptok_pkg::PH_HEADER;
					end else begin
						emit_a  = 1'b1;
						phase_d = (fmt_cur == fptok_pkg::FMT_FASTA) ? fptok_pkg::PH_SEQ
							: fptok_pkg::PH_LINE;
					end
				end
			end
			fptok_pkg::PH_HEADER: begin
				if (eol) begin
					phase_d = fptok_pkg::PH_SEQ;
				end else begin
					emit_a = 1'b1;
					kind_a = fptok_pkg::KIND_HEADER;
				end
			end
			fptok_pkg::PH_SEQ: begin
				if (!ws) begin
					emit_a = 1'b1;
					if (byte_s1 == fptok_pkg::CH_GT) begin
						kind_a  = fptok_pkg::KIND_END;
						ch_a    = fptok_pkg::CH_NUL;
						phase_d = fptok_pkg::PH_HEADER;
					end
				end
			end
			fptok_pkg::PH_PSKIP: begin
				if (!ws) begin
					emit_a  = 1'b1;
					phase_d = fptok_pkg::PH_LINE;
				end
			end
			fptok_pkg::PH_LINE: begin
				emit_a = 1'b1;
				if (eol) begin
					kind_a  = fptok_pkg::KIND_END;
					ch_a    = fptok_pkg::CH_NUL;
					phase_d = fptok_pkg::PH_PSKIP;
				end
			end
			default: begin
				phase_d = fptok_pkg::PH_START;
			end
		endcase

		fmt_d    = fmt_cur;
		emit_end = 1'b0;
		if (eoi_s1) begin
			// fasta always closes a record at end of file, plain only an open line
			emit_end = (fmt_cur == fptok_pkg::FMT_FASTA) ||
				(fmt_cur == fptok_pkg::FMT_PLAIN && phase_d == fptok_pkg::PH_LINE);
			phase_d  = fptok_pkg::PH_START;
			fmt_d    = fptok_pkg::FMT_UNDECIDED;
		end
	end

	always_comb begin
		end_tok.kind = fptok_pkg::KIND_END;
		end_tok.ch   = fptok_pkg::CH_NUL;
		end_tok.last = 1'b1;
		push.cnt     = 2'd0;
		push.tok1    = end_tok;
		if (emit_a) begin
			push.tok0.kind = kind_a;
			push.tok0.ch   = ch_a;
			push.tok0.last = !emit_end;
		end else begin
			push.tok0 = end_tok;
		end
		if (adv) begin
			push.cnt = {1'b0, emit_a} + {1'b0, emit_end};
		end
	end

endmodule

// ===== rtl/fptok_out_queue.sv =====
// ----------------------------------------------------------------------------
// fptok_out_queue
// small token queue, takes up to two tokens and gives one per cycle while out_ch is ready
// ----------------------------------------------------------------------------
module fptok_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  fptok_pkg::push_t    push,
	output logic                room,
	fptok_token_if.source       out_ch
);

	fptok_pkg::token_t                 mem [fptok_pkg::QDEPTH];
	logic [fptok_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [fptok_pkg::QCNT_W-1:0]      count_q;
	logic                              pop;
	fptok_pkg::token_t                 head;

	// room for a worst-case byte of two tokens
	assign room = count_q <= fptok_pkg::QCNT_W'(fptok_pkg::QDEPTH - 2);
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_q + fptok_pkg::QPTR_W'(1)] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fptok_pkg::QPTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fptok_pkg::QPTR_W'(1);
			end
			count_q <= count_q + fptok_pkg::QCNT_W'(push.cnt)
				- fptok_pkg::QCNT_W'(pop);
		end
	end

	assign head              = mem[rd_ptr_q];
	assign out_ch.valid      = count_q != '0;
	assign out_ch.token_kind = head.kind;
	assign out_ch.out_char   = head.ch;
	assign out_ch.run_last   = head.last;

endmodule

// ===== rtl/fasta_plain_record_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// fasta_plain_record_tokenizer_unit
// splits a FASTA or plain sequence file, one byte per transaction, into
// header bytes, sequence bytes and record-end tokens
// ----------------------------------------------------------------------------
// in_ch carries one file byte per transaction with end_of_input on the
// final byte of a file; out_ch carries tokens (kind, char, run_last), where
// run_last marks the last token that a byte produced. A byte can produce
// zero, one or two tokens.
// cfg_we/cfg_wdata set format_mode (auto, FASTA, plain); write it only
// while the unit is idle. It is read while the format of a file is open.
// an accepted byte waits in the parser's input register, and its tokens
// are written into the queue before they show on out_ch.
// throughput: one byte per cycle while each byte yields at most one
// token and out_ch is ready; the single token output port gives one
// token per cycle, so the two tokens of one byte leave one after another.
// when out_ch stalls, tokens collect in a four-entry queue; in_ch
// deasserts ready while a byte waits and the queue cannot hold two more.
// reset clears the parse state, the queue and the register to auto.
// ----------------------------------------------------------------------------
module fasta_plain_record_tokenizer_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	fptok_byte_if.sink            in_ch,
	fptok_token_if.source         out_ch,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata
);

	logic [1:0]          format_mode_q;
	logic                room;
	fptok_pkg::push_t    push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= fptok_pkg::MODE_AUTO;
		end else if (cfg_we) begin
			format_mode_q <= cfg_wdata;
		end
	end

	fptok_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_byte     (in_ch.data_byte),
		.in_eoi      (in_ch.end_of_input),
		.format_mode (format_mode_q),
		.room        (room),
		.push        (push)
	);

	fptok_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule
